>>> hw/rtl/chord_length_key_timing_unit_macros.svh
// assertion helpers
`ifndef CHORD_LENGTH_KEY_TIMING_UNIT_MACROS_SVH
`define CHORD_LENGTH_KEY_TIMING_UNIT_MACROS_SVH
`define CLKT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CLKT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

>>> hw/rtl/clkt_pkg.sv
package clkt_pkg;
    localparam int unsigned SEG_W = 22;
    localparam int unsigned TOT_W = 27;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FEW      = 2'd1;
    localparam logic [1:0] ST_ZERO_LEN = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;
    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_DURATION = 2'd1;
    localparam logic [1:0] CFG_SPEED    = 2'd2;
    // one queued point from front to back
    typedef struct packed {
        logic [43:0] sum_sq;
        logic        has_seg;
        logic        last;
    } t_pt;
endpackage

>>> hw/rtl/clkt_ram.sv
module clkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/clkt_front.sv
// takes points, squares deltas, pushes sum of squares
module clkt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [19:0]       i_pos_x,
    input  logic [19:0]       i_pos_y,
    input  logic [19:0]       i_pos_z,
    input  logic              i_last_point,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output clkt_pkg::t_pt     o_q_data
);
    logic signed [19:0] r_px, r_py, r_pz;
    logic               r_first;
    logic [20:0]        r_dx, r_dy, r_dz;
    logic               r_s1v, r_s1seg, r_s1last;
    logic [41:0]        r_qx, r_qy, r_qz;
    logic               r_s2v, r_s2seg, r_s2last;
    clkt_pkg::t_pt      r_q [2];
    logic [1:0]         r_cnt;
    logic               r_wp, r_rp;
    logic               w_acc, w_push;
    logic signed [20:0] w_ex, w_ey, w_ez;

    // one word in flight at a time keeps queue room simple
    assign o_stall = r_s1v || r_s2v || (r_cnt == 2'd2);
    assign w_acc = i_valid && !o_stall;
    assign w_ex = 21'(signed'(i_pos_x)) - 21'(r_px);
    assign w_ey = 21'(signed'(i_pos_y)) - 21'(r_py);
    assign w_ez = 21'(signed'(i_pos_z)) - 21'(r_pz);
    assign w_push = r_s2v;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_data = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_cnt <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            r_s1v <= w_acc;
            r_s2v <= r_s1v;
            if (w_acc) begin
                r_first <= i_last_point;
                r_px <= i_pos_x;
                r_py <= i_pos_y;
                r_pz <= i_pos_z;
                r_dx <= w_ex[20] ? 21'(-w_ex) : 21'(w_ex);
                r_dy <= w_ey[20] ? 21'(-w_ey) : 21'(w_ey);
                r_dz <= w_ez[20] ? 21'(-w_ez) : 21'(w_ez);
                r_s1seg <= !r_first;
                r_s1last <= i_last_point;
            end
            if (r_s1v) begin
                r_qx <= r_dx * r_dx;
                r_qy <= r_dy * r_dy;
                r_qz <= r_dz * r_dz;
                r_s2seg <= r_s1seg;
                r_s2last <= r_s1last;
            end
            if (w_push) begin
                r_q[r_wp] <= '{sum_sq: 44'(r_qx) + 44'(r_qy) + 44'(r_qz),
                               has_seg: r_s2seg, last: r_s2last};
                r_wp <= !r_wp;
            end
            if (i_q_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    `include "chord_length_key_timing_unit_macros.svh"
    `CLKT_NEVER(a_q_over, i_clk, i_rst_n, w_push && !i_q_pop && r_cnt == 2'd2, "queue overflow")
    `CLKT_NEVER(a_q_under, i_clk, i_rst_n, i_q_pop && r_cnt == 2'd0, "queue underflow")
    `CLKT_ASSERT(a_stage, i_clk, i_rst_n, r_s1v |=> r_s2v, "stage lost")
endmodule

>>> hw/rtl/clkt_back.sv
// root per segment, then key emission with serial divides
module clkt_back #(
    parameter int MAX_POINTS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_pop,
    input  clkt_pkg::t_pt     i_q_data,
    input  logic              i_mode,
    input  logic [31:0]       i_duration,
    input  logic [31:0]       i_speed,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [4:0]        o_key_index,
    output logic [31:0]       o_key_time,
    output logic [16:0]       o_key_param,
    output logic [1:0]        o_status,
    output logic              o_last_key
);
    localparam int DEP = MAX_POINTS - 1;
    localparam int AW = (DEP > 1) ? $clog2(DEP) : 1;
    localparam int CW = $clog2(MAX_POINTS + 2);
    localparam int NUMW = 64;

    typedef enum logic [2:0] {S_IDLE, S_ROOT, S_DECIDE, S_READ, S_DIV, S_PAR, S_OUT}
        t_state;
    t_state r_state;

    logic [43:0] r_rem, r_res, r_bit;
    logic        r_last;
    logic [CW-1:0] r_cnt, r_i;
    logic [clkt_pkg::TOT_W-1:0] r_tot;
    logic [31:0] r_cum;
    logic [NUMW-1:0] r_num, r_quo;
    logic [32:0] r_den;
    logic [NUMW:0] r_acc;
    logic [6:0]  r_step;
    logic [31:0] r_time;
    logic        r_ok;
    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [clkt_pkg::SEG_W-1:0] w_rdata;
    logic [NUMW:0] w_sh;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_we = (r_state == S_ROOT) && (r_bit == '0) && r_ok;
    assign w_waddr = AW'(r_cnt - CW'(1));
    // segment i feeds key i+1; fetched while key i is held
    assign w_raddr = AW'(r_i);
    assign w_sh = {r_acc[NUMW-1:0], r_num[NUMW-1]};

    clkt_ram #(.WIDTH(clkt_pkg::SEG_W), .DEPTH(DEP)) u_seg (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata(r_res[clkt_pkg::SEG_W-1:0]), .i_raddr(w_raddr), .o_rdata(w_rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_tot <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_q_valid) begin
                    r_last <= i_q_data.last;
                    r_rem <= i_q_data.sum_sq;
                    r_res <= '0;
                    r_bit <= 44'h1 << 42;
                    r_ok <= i_q_data.has_seg && r_cnt < CW'(MAX_POINTS);
                    if (r_cnt == '0) begin
                        r_cnt <= CW'(1);
                        r_state <= S_DECIDE;
                    end else if (i_q_data.has_seg && r_cnt < CW'(MAX_POINTS))
                        r_state <= S_ROOT;
                    else begin
                        r_cnt <= CW'(MAX_POINTS + 1);
                        r_state <= S_DECIDE;
                    end
                end
                S_ROOT: begin
                    if (r_bit == '0) begin
                        r_tot <= r_tot + clkt_pkg::TOT_W'(r_res[clkt_pkg::SEG_W-1:0]);
                        r_cnt <= r_cnt + CW'(1);
                        r_state <= S_DECIDE;
                    end else begin
                        if (r_rem >= r_res + r_bit) begin
                            r_rem <= r_rem - (r_res + r_bit);
                            r_res <= (r_res >> 1) + r_bit;
                        end else r_res <= r_res >> 1;
                        r_bit <= r_bit >> 2;
                    end
                end
                S_DECIDE: begin
                    if (!r_last) r_state <= S_IDLE;
                    else if (r_cnt > CW'(MAX_POINTS) || r_cnt < CW'(2) || r_tot == '0) begin
                        o_key_index <= '0;
                        o_key_time <= '0;
                        o_key_param <= '0;
                        o_last_key <= 1'b1;
                        o_status <= (r_cnt > CW'(MAX_POINTS)) ? clkt_pkg::ST_DROPPED :
                                    (r_cnt < CW'(2)) ? clkt_pkg::ST_FEW :
                                    clkt_pkg::ST_ZERO_LEN;
                        o_valid <= 1'b1;
                        r_i <= r_cnt;
                        r_state <= S_OUT;
                    end else begin
                        r_i <= '0;
                        r_cum <= '0;
                        r_time <= '0;
                        r_num <= '0;
                        r_den <= 33'd1;
                        r_step <= 7'd64;
                        r_acc <= '0;
                        r_state <= S_PAR;
                    end
                end
                S_READ: begin
                    // divisor and dividend for the key time
                    if (i_mode == 1'b0) begin
                        r_num <= NUMW'(i_duration) * NUMW'(r_cum + 32'(w_rdata));
                        r_den <= 33'(r_tot);
                    end else begin
                        r_num <= NUMW'(r_cum + 32'(w_rdata)) << 24;
                        r_den <= {1'b0, i_speed};
                    end
                    r_cum <= r_cum + 32'(w_rdata);
                    r_acc <= '0;
                    r_step <= 7'd64;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        if (i_mode == 1'b1 && (i_speed == '0 || r_quo[NUMW-1:32] != '0))
                            r_time <= '1;
                        else r_time <= r_quo[31:0];
                        r_num <= NUMW'(r_i) << 16;
                        r_den <= 33'(r_cnt - CW'(1));
                        r_acc <= '0;
                        r_step <= 7'd64;
                        r_state <= S_PAR;
                    end else begin
                        if (w_sh >= 65'(r_den)) begin
                            r_acc <= w_sh - 65'(r_den);
                            r_quo <= {r_quo[NUMW-2:0], 1'b1};
                        end else begin
                            r_acc <= w_sh;
                            r_quo <= {r_quo[NUMW-2:0], 1'b0};
                        end
                        r_num <= r_num << 1;
                        r_step <= r_step - 7'd1;
                    end
                end
                S_PAR: begin
                    if (r_step == '0) begin
                        o_key_index <= 5'(r_i);
                        o_key_time <= r_time;
                        o_key_param <= (r_i == r_cnt - CW'(1)) ? 17'h10000 : r_quo[16:0];
                        o_status <= clkt_pkg::ST_OK;
                        o_last_key <= (r_i == r_cnt - CW'(1));
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        if (w_sh >= 65'(r_den)) begin
                            r_acc <= w_sh - 65'(r_den);
                            r_quo <= {r_quo[NUMW-2:0], 1'b1};
                        end else begin
                            r_acc <= w_sh;
                            r_quo <= {r_quo[NUMW-2:0], 1'b0};
                        end
                        r_num <= r_num << 1;
                        r_step <= r_step - 7'd1;
                    end
                end
                S_OUT: if (!i_stall) begin
                    o_valid <= 1'b0;
                    if (o_last_key) begin
                        r_cnt <= '0;
                        r_tot <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i + CW'(1);
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "chord_length_key_timing_unit_macros.svh"
    `CLKT_ASSERT(a_out_state, i_clk, i_rst_n, o_valid |-> r_state == S_OUT, "valid outside output")
    `CLKT_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid && $stable(o_key_time), "word dropped")
    `CLKT_NEVER(a_cnt, i_clk, i_rst_n, r_cnt > CW'(MAX_POINTS + 1), "count out of range")
endmodule

>>> hw/rtl/chord_length_key_timing_unit.sv
// Points: the first point only opens the path; each later point runs a 22-step root.
// Emission: two 64-step serial divides per key (one for key 0), output register.
// The back end takes one point at a time through the serial root; the front queues up to two.
// Reset: synchronous active low; clears run state, config to reset values.
// Segment memory needs no clearing pass.
module chord_length_key_timing_unit #(
    parameter int MAX_POINTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_pos_x,
    input  logic [19:0] i_pos_y,
    input  logic [19:0] i_pos_z,
    input  logic        i_last_point,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_key_index,
    output logic [31:0] o_key_time,
    output logic [16:0] o_key_param,
    output logic [1:0]  o_status,
    output logic        o_last_key,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic        r_mode;
    logic [31:0] r_duration, r_speed;
    logic        w_qv, w_pop;
    clkt_pkg::t_pt w_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_duration <= 32'd65536;
            r_speed <= 32'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clkt_pkg::CFG_MODE:     r_mode <= i_cfg_data[0];
                clkt_pkg::CFG_DURATION: r_duration <= i_cfg_data;
                clkt_pkg::CFG_SPEED:    r_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    clkt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_last_point(i_last_point), .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_data(w_qd));

    clkt_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_q_data(w_qd), .i_mode(r_mode), .i_duration(r_duration), .i_speed(r_speed),
        .o_valid(o_valid), .i_stall(i_stall), .o_key_index(o_key_index),
        .o_key_time(o_key_time), .o_key_param(o_key_param), .o_status(o_status),
        .o_last_key(o_last_key));
endmodule

>>> bench/chord_length_key_timing_unit_checker.sv
module chord_length_key_timing_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [19:0] i_pos_x,
    input  logic [19:0] i_pos_y,
    input  logic [19:0] i_pos_z,
    input  logic        i_last_point,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [4:0]  i_key_index,
    input  logic [31:0] i_key_time,
    input  logic [16:0] i_key_param,
    input  logic [1:0]  i_status,
    input  logic        i_last_key,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int MAX_PTS = 32;

    typedef struct packed {
        logic [4:0]  index;
        logic [31:0] key_time;
        logic [16:0] param;
        logic [1:0]  status;
        logic        last;
    } t_key;

    t_key key_q[$];

    logic        mode;
    logic [31:0] duration;
    logic [31:0] speed;
    longint      last_x, last_y, last_z;
    logic [21:0] seg_len[MAX_PTS-1];
    logic [26:0] path_len;
    int          pts;
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = key_q.size();

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned sq(input longint d);
        longint unsigned m;
        m = (d < 0) ? longint'(-d) : longint'(d);
        return m * m;
    endfunction

    task automatic push_error(input logic [1:0] st);
        t_key k;
        k = '{index: 5'd0, key_time: 32'd0, param: 17'd0, status: st, last: 1'b1};
        key_q.push_back(k);
    endtask

    task automatic clear_path();
        last_x = 0;
        last_y = 0;
        last_z = 0;
        path_len = '0;
        pts = 0;
    endtask

    task automatic take_point(input logic [19:0] px, input logic [19:0] py,
                              input logic [19:0] pz, input logic lst);
        longint x, y, z;
        longint unsigned s, cum, t;
        logic [21:0] len;
        t_key k;
        x = longint'($signed(px));
        y = longint'($signed(py));
        z = longint'($signed(pz));
        if (pts == 0) begin
            last_x = x; last_y = y; last_z = z;
            pts = 1;
        end else if (pts < MAX_PTS) begin
            s = sq(x - last_x) + sq(y - last_y) + sq(z - last_z);
            len = 22'(int_root(s));
            seg_len[pts-1] = len;
            path_len = path_len + len;
            last_x = x; last_y = y; last_z = z;
            pts++;
        end else begin
            pts = MAX_PTS + 1;
        end
        if (!lst) return;
        if (pts > MAX_PTS) push_error(clkt_pkg::ST_DROPPED);
        else if (pts < 2) push_error(clkt_pkg::ST_FEW);
        else if (path_len == 0) push_error(clkt_pkg::ST_ZERO_LEN);
        else begin
            cum = 0;
            for (int i = 0; i < pts; i++) begin
                if (i > 0) cum += seg_len[i-1];
                if (i == 0) t = 0;
                else if (mode == 1'b0) t = (longint'(duration) * cum) / path_len;
                else if (speed == 0) t = 64'hFFFF_FFFF;
                else begin
                    t = (cum << 24) / speed;
                    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
                end
                k.index    = i[4:0];
                k.key_time = t[31:0];
                k.param    = (i == pts - 1) ? 17'd65536 : 17'((i * 65536) / (pts - 1));
                k.status   = clkt_pkg::ST_OK;
                k.last     = (i == pts - 1);
                key_q.push_back(k);
            end
        end
        clear_path();
    endtask

    initial begin
        fails = 0;
        mode = 1'b0;
        duration = 32'd65536;
        speed = 32'd65536;
        clear_path();
    end

    always @(posedge i_clk) begin
        t_key e;
        if (!i_rst_n) begin
            mode <= 1'b0;
            duration <= 32'd65536;
            speed <= 32'd65536;
            clear_path();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    clkt_pkg::CFG_MODE:     mode <= i_cfg_data[0];
                    clkt_pkg::CFG_DURATION: duration <= i_cfg_data;
                    clkt_pkg::CFG_SPEED:    speed <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall)
                take_point(i_pos_x, i_pos_y, i_pos_z, i_last_point);
            if (i_out_valid && !i_out_stall) begin
                if (key_q.size() == 0) begin
                    $error("unexpected word: index %0d time %0h", i_key_index, i_key_time);
                    fails++;
                end else begin
                    e = key_q.pop_front();
                    if (i_key_index !== e.index) begin
                        $error("key_index: expected %0d, got %0d", e.index, i_key_index);
                        fails++;
                    end
                    if (i_key_time !== e.key_time) begin
                        $error("key_time: expected %0h, got %0h", e.key_time, i_key_time);
                        fails++;
                    end
                    if (i_key_param !== e.param) begin
                        $error("key_param: expected %0d, got %0d", e.param, i_key_param);
                        fails++;
                    end
                    if (i_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, i_status);
                        fails++;
                    end
                    if (i_last_key !== e.last) begin
                        $error("last_key: expected %0b, got %0b", e.last, i_last_key);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

>>> bench/chord_length_key_timing_unit_tb.sv
module chord_length_key_timing_unit_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [19:0] i_pos_x, i_pos_y, i_pos_z;
    logic        i_last_point;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [4:0]  o_key_index;
    logic [31:0] o_key_time;
    logic [16:0] o_key_param;
    logic [1:0]  o_status;
    logic        o_last_key;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          points_sent;
    int          hold_cnt = 0;

    chord_length_key_timing_unit DUT (.*);

    chord_length_key_timing_unit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_stall(o_stall),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_last_point(i_last_point),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_key_index(o_key_index), .i_key_time(o_key_time),
        .i_key_param(o_key_param), .i_status(o_status), .i_last_key(o_last_key),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #100_000_000;
        $display("FAIL chord_length_key_timing_unit");
        $finish;
    end

    // receiver back-pressure: short stalls, occasional long ones, quiet stretches
    always @(negedge i_clk) begin : stall_gen
        int r;
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                i_stall <= 1'b0;
                hold_cnt <= $urandom_range(0, 8);
            end else if (r < 88) begin
                i_stall <= 1'b1;
                hold_cnt <= $urandom_range(0, 3);
            end else if (r < 94) begin
                i_stall <= 1'b1;
                hold_cnt <= $urandom_range(10, 60);
            end else begin
                i_stall <= 1'b0;
                hold_cnt <= $urandom_range(100, 400);
            end
        end
    end

    task automatic send_word(input logic [19:0] x, input logic [19:0] y,
                             input logic [19:0] z, input logic lst);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        i_last_point <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        points_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // kind 0: full range, 1: small steps around a base, 2: one repeated point
    task automatic send_path(input int n, input int kind);
        logic [19:0] bx, by, bz, x, y, z;
        bx = 20'($urandom);
        by = 20'($urandom);
        bz = 20'($urandom);
        for (int i = 0; i < n; i++) begin
            case (kind)
                0: begin x = 20'($urandom); y = 20'($urandom); z = 20'($urandom); end
                1: begin
                    x = 20'(bx + $urandom_range(0, 512) - 256);
                    y = 20'(by + $urandom_range(0, 512) - 256);
                    z = 20'(bz + $urandom_range(0, 512) - 256);
                end
                default: begin x = bx; y = by; z = bz; end
            endcase
            send_word(x, y, z, i == n - 1);
        end
    endtask

    task automatic extremes_path();
        send_word(20'h80000, 20'h80000, 20'h80000, 1'b0);
        send_word(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b0);
        send_word(20'h00000, 20'h00000, 20'h00000, 1'b1);
    endtask

    task automatic random_config();
        int r;
        r = $urandom_range(0, 9);
        write_reg(clkt_pkg::CFG_MODE, $urandom_range(0, 1));
        write_reg(clkt_pkg::CFG_DURATION,
                  (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'd0 : $urandom);
        write_reg(clkt_pkg::CFG_SPEED, (r == 2) ? 32'hFFFF_FFFF : (r == 3) ? 32'd1 :
                             (r == 4) ? 32'd0 : $urandom_range(1, 32'h0100_0000));
    endtask

    initial begin
        int r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_last_point = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = clkt_pkg::CFG_MODE;
        i_cfg_data = '0;
        points_sent = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset config, single point, zero length, extremes
        send_word(20'h12345, 20'h80000, 20'h7FFFF, 1'b1);
        send_path(2, 2);
        extremes_path();
        wait_idle();
        write_reg(clkt_pkg::CFG_DURATION, 32'hFFFF_FFFF);
        extremes_path();
        wait_idle();
        write_reg(clkt_pkg::CFG_DURATION, 32'd0);
        send_path(3, 1);
        wait_idle();
        write_reg(clkt_pkg::CFG_MODE, 32'd1);
        write_reg(clkt_pkg::CFG_SPEED, 32'd0);
        send_path(3, 0);
        wait_idle();
        write_reg(clkt_pkg::CFG_SPEED, 32'd1);
        extremes_path();
        wait_idle();
        write_reg(clkt_pkg::CFG_SPEED, 32'hFFFF_FFFF);
        send_path(4, 1);
        wait_idle();

        while (points_sent < 430) begin
            random_config();
            repeat ($urandom_range(2, 6)) begin
                r = $urandom_range(0, 99);
                if (r < 60) send_path($urandom_range(2, 8), $urandom_range(0, 1));
                else if (r < 72) send_path($urandom_range(9, 32), $urandom_range(0, 1));
                else if (r < 80) send_path($urandom_range(33, 36), 1);
                else if (r < 87) send_path(1, 0);
                else if (r < 94) send_path($urandom_range(2, 5), 2);
                else send_path(32, 1);
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("PASS chord_length_key_timing_unit");
        end else begin
            $display("FAIL chord_length_key_timing_unit");
        end
        $finish;
    end
endmodule
